### src/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and constants for the nearest neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

  localparam int COORD_W    = 12;
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 9;
  // One bit above the register width, so that unity still fits at 16 fraction bits.
  localparam int ZOOM_W     = 17;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DIM_W      = 12;

  localparam logic [PIX_W-1:0] PIX_OUTSIDE = 8'hFF;
  localparam logic [DIM_W-1:0] DIM_SAT     = 12'hFFF;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_X_ZOOM        = 3'd2,
    REG_Y_ZOOM        = 3'd3,
    REG_X_STEP        = 3'd4,
    REG_Y_STEP        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] source_width;
    logic [SIZE_W-1:0] source_height;
    logic [ZOOM_W-1:0] x_zoom;
    logic [ZOOM_W-1:0] y_zoom;
    logic [ZOOM_W-1:0] x_step;
    logic [ZOOM_W-1:0] y_step;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel;
  } item_t;

  // Control that travels with a transaction to the frame store stage.
  // For loads, hit means the coordinates are inside the store; for requests,
  // hit means the mapped source pixel is inside the source image.
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  hit;
  } acc_ctl_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   int unsigned max_dim);
    return (32'(v) > max_dim) ? SIZE_W'(max_dim) : v;
  endfunction

endpackage

### src/nnis_map.sv
// ----------------------------------------------------------------------------
// nnis_map
// Two pipeline stages: multiply by the step, then round, bound and address.
// ----------------------------------------------------------------------------
module nnis_map #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 12,
  parameter int AW        = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  nnis_pkg::item_t                  in_item,
  input  nnis_pkg::cfg_t                   cfg,
  output nnis_pkg::acc_ctl_t               ctl,
  output logic [AW-1:0]                    row_addr,
  output logic [AW-1:0]                    col_addr,
  output logic [nnis_pkg::PIX_W-1:0]       pixel
);
  import nnis_pkg::*;

  localparam int PROD_W = COORD_W + ZOOM_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SRC_W  = SUM_W - FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic              va_r;
  item_t             item_a_r;
  logic [PROD_W-1:0] prod_row_r;
  logic [PROD_W-1:0] prod_col_r;

  logic [SUM_W-1:0]  sum_row, sum_col;
  logic [SRC_W-1:0]  src_row, src_col;
  logic [SIZE_W-1:0] lim_w, lim_h;
  logic              in_image, load_ok;
  acc_ctl_t          ctl_nxt;
  logic [AW-1:0]     row_addr_nxt, col_addr_nxt;

  acc_ctl_t          ctl_r;
  logic [AW-1:0]     row_addr_r, col_addr_r;
  logic [PIX_W-1:0]  pixel_r;

  // Stage A: products of the coordinates and the steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
    item_a_r   <= in_item;
    prod_row_r <= PROD_W'(in_item.row) * PROD_W'(cfg.y_step);
    prod_col_r <= PROD_W'(in_item.col) * PROD_W'(cfg.x_step);
  end

  // Stage B: round half up, test against the source size, form the address.
  always_comb begin
    sum_row  = SUM_W'(prod_row_r) + HALF;
    sum_col  = SUM_W'(prod_col_r) + HALF;
    src_row  = sum_row[SUM_W-1:FRAC_BITS];
    src_col  = sum_col[SUM_W-1:FRAC_BITS];
    lim_w    = clamp_size(cfg.source_width, MAX_DIM);
    lim_h    = clamp_size(cfg.source_height, MAX_DIM);
    in_image = (src_row < SRC_W'(lim_h)) && (src_col < SRC_W'(lim_w));
    load_ok  = (32'(item_a_r.row) < MAX_DIM) && (32'(item_a_r.col) < MAX_DIM);

    ctl_nxt.valid = va_r;
    ctl_nxt.kind  = item_a_r.kind;
    if (item_a_r.kind == KIND_LOAD) begin
      ctl_nxt.hit  = load_ok;
      row_addr_nxt = item_a_r.row[AW-1:0];
      col_addr_nxt = item_a_r.col[AW-1:0];
    end else begin
      ctl_nxt.hit  = in_image;
      row_addr_nxt = src_row[AW-1:0];
      col_addr_nxt = src_col[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
    row_addr_r <= row_addr_nxt;
    col_addr_r <= col_addr_nxt;
    pixel_r    <= item_a_r.pixel;
  end

  assign ctl      = ctl_r;
  assign row_addr = row_addr_r;
  assign col_addr = col_addr_r;
  assign pixel    = pixel_r;

endmodule

### src/nnis_dim.sv
// ----------------------------------------------------------------------------
// nnis_dim
// Scaled image dimensions: source size times zoom, rounded and saturated.
// ----------------------------------------------------------------------------
module nnis_dim #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  nnis_pkg::cfg_t              cfg,
  output logic [nnis_pkg::DIM_W-1:0]  width,
  output logic [nnis_pkg::DIM_W-1:0]  height
);
  import nnis_pkg::*;

  localparam int PROD_W   = SIZE_W + ZOOM_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int SCALED_W = SUM_W - FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic [PROD_W-1:0]   prod_w_r, prod_h_r;
  logic [SUM_W-1:0]    sum_w, sum_h;
  logic [SCALED_W-1:0] scaled_w, scaled_h;
  logic [DIM_W-1:0]    width_nxt, height_nxt;
  logic [DIM_W-1:0]    width_r, height_r;

  always_ff @(posedge clk) begin
    prod_w_r <= PROD_W'(clamp_size(cfg.source_width, MAX_DIM)) * PROD_W'(cfg.x_zoom);
    prod_h_r <= PROD_W'(clamp_size(cfg.source_height, MAX_DIM)) * PROD_W'(cfg.y_zoom);
  end

  always_comb begin
    sum_w      = SUM_W'(prod_w_r) + HALF;
    sum_h      = SUM_W'(prod_h_r) + HALF;
    scaled_w   = sum_w[SUM_W-1:FRAC_BITS];
    scaled_h   = sum_h[SUM_W-1:FRAC_BITS];
    width_nxt  = (32'(scaled_w) > 32'(DIM_SAT)) ? DIM_SAT : DIM_W'(scaled_w);
    height_nxt = (32'(scaled_h) > 32'(DIM_SAT)) ? DIM_SAT : DIM_W'(scaled_h);
  end

  always_ff @(posedge clk) begin
    width_r  <= width_nxt;
    height_r <= height_nxt;
  end

  assign width  = width_r;
  assign height = height_r;

endmodule

### src/nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Nearest neighbor scaler for 8-bit grayscale images with a frame store.
// ----------------------------------------------------------------------------
// One transaction is taken every clock; busy never rises. A load writes one
// pixel into the frame store and gives no result. A request gives its result
// on the out_ ports, marked by out_valid for one cycle, once it has passed
// its stages: one for the step multiplies, one for rounding and the bounds
// test, one for the registered read of the single-port frame store.
// The receiver cannot stall, so it must take a result in the cycle it shows.
// The frame store is not cleared; request only pixels that were loaded.
// Register writes are taken at once and should be made while no request is
// in flight; the reported dimensions follow a write through the product and result registers.
module nearest_neighbor_image_scaler #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_kind,
  input  logic [nnis_pkg::COORD_W-1:0]      in_row,
  input  logic [nnis_pkg::COORD_W-1:0]      in_col,
  input  logic [nnis_pkg::PIX_W-1:0]        in_pixel_in,
  output logic                              out_valid,
  output logic [nnis_pkg::PIX_W-1:0]        out_pixel_out,
  output logic                              out_outside,
  output logic [nnis_pkg::DIM_W-1:0]        out_out_width,
  output logic [nnis_pkg::DIM_W-1:0]        out_out_height,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nnis_pkg::*;

  localparam int AW = $clog2(MAX_DIM);
  localparam logic [ZOOM_W-1:0] UNITY = ZOOM_W'(1) << FRAC_BITS;

  cfg_t             cfg_r, cfg_nxt;
  item_t            in_item;
  logic             in_accept;
  acc_ctl_t         ctl;
  logic [AW-1:0]    row_addr, col_addr;
  logic [PIX_W-1:0] st_pixel;

  logic [PIX_W-1:0] frame_mem [2**(2*AW)];
  logic [PIX_W-1:0] rd_data_r;
  logic             vc_r, outside_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  assign in_item.kind  = kind_t'(in_kind);
  assign in_item.row   = in_row;
  assign in_item.col   = in_col;
  assign in_item.pixel = in_pixel_in;

  // Configuration registers.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  cfg_nxt.source_width  = cfg_data[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: cfg_nxt.source_height = cfg_data[SIZE_W-1:0];
        REG_X_ZOOM:        cfg_nxt.x_zoom        = ZOOM_W'(cfg_data);
        REG_Y_ZOOM:        cfg_nxt.y_zoom        = ZOOM_W'(cfg_data);
        REG_X_STEP:        cfg_nxt.x_step        = ZOOM_W'(cfg_data);
        REG_Y_STEP:        cfg_nxt.y_step        = ZOOM_W'(cfg_data);
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width  <= SIZE_W'(256);
      cfg_r.source_height <= SIZE_W'(256);
      cfg_r.x_zoom        <= UNITY;
      cfg_r.y_zoom        <= UNITY;
      cfg_r.x_step        <= UNITY;
      cfg_r.y_step        <= UNITY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nnis_map #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_accept),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .ctl      (ctl),
    .row_addr (row_addr),
    .col_addr (col_addr),
    .pixel    (st_pixel)
  );

  nnis_dim #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dim (
    .clk    (clk),
    .cfg    (cfg_r),
    .width  (out_out_width),
    .height (out_out_height)
  );

  // Frame store: one access a cycle, loads and requests in arrival order.
  always_ff @(posedge clk) begin
    if (ctl.valid && ctl.kind == KIND_LOAD && ctl.hit) begin
      frame_mem[{row_addr, col_addr}] <= st_pixel;
    end
    rd_data_r <= frame_mem[{row_addr, col_addr}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= ctl.valid && ctl.kind == KIND_REQUEST;
    end
    outside_r <= !ctl.hit;
  end

  assign out_valid     = vc_r;
  assign out_outside   = outside_r;
  assign out_pixel_out = outside_r ? PIX_OUTSIDE : rd_data_r;

  // A result is always the answer to an earlier accepted request.
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept && in_kind == KIND_REQUEST, 3))
    else $error("result without a matching request");

  // A load transaction never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_kind == KIND_LOAD) |-> ##3 !out_valid)
    else $error("load produced a result");

  // A request accepted out of reset always produces its result.
  a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_kind == KIND_REQUEST) |-> ##3 (out_valid || !$past(rst_n, 2)))
    else $error("request lost in the pipeline");

endmodule
